// ===== rtl/core/lfbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lfbr_pkg
// types and constants shared by the length framed byte receiver modules
// ----------------------------------------------------------------------------
`default_nettype none

package lfbr_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LIMIT_W     = 6;
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    // wide enough for any count, length byte plus header, or limit compare
    localparam int unsigned CMP_W = 10;

    localparam logic [BYTE_W-1:0]  SYNC_BYTE_RESET      = 8'hEF;
    localparam logic [LIMIT_W-1:0] OVERFLOW_LIMIT_RESET = 6'd50;

    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OVERFLOW_LIMIT = 2'd1;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  frame_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               last;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RECV,
        ST_EMIT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic store;
        logic emit_start;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic sync_match;
        logic full;
        logic complete;
        logic overflow;
        logic emit_done;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfbr_ctrl
// frame state machine: hunts for sync, receives, walks out the frame, holds
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    input  wire logic             item_op,
    output logic                  item_stall,
    input  wire lfbr_pkg::status_t status,
    output lfbr_pkg::cmd_t        cmd
);

    lfbr_pkg::state_t state_reg;
    lfbr_pkg::state_t state_next;
    logic             accept;

    assign item_stall = (state_reg == lfbr_pkg::ST_EMIT);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfbr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lfbr_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_op == lfbr_pkg::OP_RELEASE)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else if (status.sync_match)
                    begin
                        cmd.start  = 1'b1;
                        state_next = lfbr_pkg::ST_RECV;
                    end
                end
            end
            lfbr_pkg::ST_RECV:
            begin
                if (accept)
                begin
                    if (item_op == lfbr_pkg::OP_RELEASE || status.full)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = lfbr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        // completion wins over overflow on the same byte
                        if (status.complete)
                        begin
                            cmd.emit_start = 1'b1;
                            state_next     = lfbr_pkg::ST_EMIT;
                        end
                        else if (status.overflow)
                        begin
                            cmd.clear  = 1'b1;
                            state_next = lfbr_pkg::ST_IDLE;
                        end
                    end
                end
            end
            lfbr_pkg::ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = lfbr_pkg::ST_HOLD;
                end
            end
            lfbr_pkg::ST_HOLD:
            begin
                if (accept && item_op == lfbr_pkg::OP_RELEASE)
                begin
                    cmd.clear  = 1'b1;
                    state_next = lfbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lfbr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/lfbr_datapath.sv =====
// ----------------------------------------------------------------------------
// lfbr_datapath
// config registers, byte counter, frame store and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module lfbr_datapath
#(
    parameter int unsigned FRAME_DEPTH  = 64,
    parameter int unsigned LENGTH_POS   = 8,
    parameter int unsigned HEADER_EXTRA = 9
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [lfbr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [lfbr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [lfbr_pkg::BYTE_W-1:0]           rx_byte,
    input  wire lfbr_pkg::cmd_t                        cmd,
    output lfbr_pkg::status_t                          status,
    output logic                                       result_valid,
    input  wire logic                                  result_stall,
    output lfbr_pkg::result_t                          result
);

    localparam int unsigned ADDR_W = $clog2(FRAME_DEPTH);
    localparam int unsigned CNT_W  = $clog2(FRAME_DEPTH + 1);
    localparam int unsigned CMP_W  = lfbr_pkg::CMP_W;

    logic [lfbr_pkg::BYTE_W-1:0]  sync_reg;
    logic [lfbr_pkg::LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_inc;
    logic [CNT_W-1:0]             idx_reg;
    logic [lfbr_pkg::BYTE_W-1:0]  first_reg;
    logic [lfbr_pkg::BYTE_W-1:0]  len_reg;
    logic [lfbr_pkg::BYTE_W-1:0]  len_byte;
    logic [lfbr_pkg::BYTE_W-1:0]  store_mem [FRAME_DEPTH];
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         rd_fire;
    logic                         result_valid_reg;
    lfbr_pkg::result_t            result_reg;
    logic [CNT_W+5:0]             idx_wide;
    logic [CMP_W-1:0]             count_inc_w;
    logic [CMP_W-1:0]             frame_len_w;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg  <= lfbr_pkg::SYNC_BYTE_RESET;
            limit_reg <= lfbr_pkg::OVERFLOW_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfbr_pkg::REG_SYNC_BYTE:
                begin
                    sync_reg <= cfg_data;
                end
                lfbr_pkg::REG_OVERFLOW_LIMIT:
                begin
                    limit_reg <= cfg_data[lfbr_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // frame status for the byte being offered
    assign count_inc   = count_reg + CNT_W'(1);
    assign count_inc_w = CMP_W'(count_inc);
    // length byte arrives now or was captured earlier
    assign len_byte    = (CMP_W'(count_reg) == CMP_W'(LENGTH_POS)) ? rx_byte : len_reg;
    assign frame_len_w = CMP_W'(len_byte) + CMP_W'(HEADER_EXTRA);

    assign status.sync_match = (rx_byte == sync_reg);
    assign status.full       = (CMP_W'(count_reg) >= CMP_W'(FRAME_DEPTH));
    assign status.complete   = (count_inc_w > CMP_W'(LENGTH_POS))
                             && (first_reg == sync_reg)
                             && (count_inc_w == frame_len_w);
    assign status.overflow   = (count_inc_w > CMP_W'(limit_reg))
                             || (count_inc_w >= CMP_W'(FRAME_DEPTH));
    assign status.emit_done  = (idx_reg == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.start)
            begin
                count_reg <= CNT_W'(1);
            end
            else if (cmd.store)
            begin
                count_reg <= count_inc;
            end

            if (cmd.emit_start)
            begin
                idx_reg <= '0;
            end
            else if (rd_fire)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            first_reg <= rx_byte;
        end
        if (cmd.store && CMP_W'(count_reg) == CMP_W'(LENGTH_POS))
        begin
            len_reg <= rx_byte;
        end
    end

    // frame store write port
    assign wr_en   = cmd.start || cmd.store;
    assign wr_addr = cmd.start ? '0 : count_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= rx_byte;
        end
    end

    // frame store read port feeds the result register directly
    assign rd_fire  = cmd.emit && (idx_reg < count_reg)
                    && (!result_valid_reg || !result_stall);
    assign idx_wide = {6'b0, idx_reg};

    always_ff @(posedge clk)
    begin
        if (rd_fire)
        begin
            result_reg.frame_byte <= store_mem[idx_reg[ADDR_W-1:0]];
            result_reg.byte_index <= idx_wide[lfbr_pkg::INDEX_W-1:0];
            result_reg.last       <= (CMP_W'(idx_reg) + CMP_W'(1) == CMP_W'(count_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (rd_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(FRAME_DEPTH))
        else $error("byte count beyond frame store depth");

    a_store_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (CMP_W'(count_reg) < CMP_W'(FRAME_DEPTH)))
        else $error("store request with frame store full");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.start && cmd.store))
        else $error("start and store requested together");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire |-> (idx_reg < count_reg) && !cmd.store && !cmd.start)
        else $error("frame read outside frame or during receive");

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire && (CMP_W'(idx_reg) + CMP_W'(1) == CMP_W'(count_reg))
            |=> result_valid && result.last)
        else $error("last byte not flagged");

endmodule

`default_nettype wire

// ===== rtl/core/length_framed_byte_receiver.sv =====
// ----------------------------------------------------------------------------
// length_framed_byte_receiver
// assembles length prefixed command frames from a byte stream
// ----------------------------------------------------------------------------
// item channel (item_valid / item_stall / item): op selects a received byte
// or a release. while idle a byte equal to the sync register opens a frame;
// later bytes are stored until the count equals the length byte plus the
// header size, then the frame is sent on the result channel.
// one item is taken per cycle while receiving, idle or holding.
// result channel (result_valid / result_stall / result): one request per
// frame byte with its index, last set on the final byte. the first byte is
// valid after the state register enters the emit state and the frame store
// read loads the result register, then one byte per cycle while not stalled,
// paced by the single frame store read port; item_stall is high during the walk.
// after the walk the block holds and drops bytes until a release item.
// a frame that passes the overflow limit or fills the store before it completes is dropped.
// config port: cfg_we / cfg_index / cfg_data; the user writes it only while no frame
// bytes are pending, which the block does not enforce; writes to unknown indexes are ignored.
// reset: idle, sync byte 0xef, overflow limit 50, no result pending.
// a stalled result holds its byte; the walk simply pauses.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_byte_receiver
#(
    parameter int unsigned FRAME_DEPTH  = 64,
    parameter int unsigned LENGTH_POS   = 8,
    parameter int unsigned HEADER_EXTRA = 9
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lfbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lfbr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire lfbr_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output lfbr_pkg::result_t                     result
);

    lfbr_pkg::cmd_t    cmd;
    lfbr_pkg::status_t status;

    lfbr_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.op),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    lfbr_datapath
    #(
        .FRAME_DEPTH  (FRAME_DEPTH),
        .LENGTH_POS   (LENGTH_POS),
        .HEADER_EXTRA (HEADER_EXTRA)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (item.rx_byte),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
